// ----- hw/rtl/pwt_pkg.sv -----
// ----------------------------------------------------------------------------
// pwt_pkg
// Types and codes shared by the protobuf wire tokenizer modules.
// ----------------------------------------------------------------------------
package pwt_pkg;

  localparam logic [2:0] KIND_VARINT  = 3'd0;
  localparam logic [2:0] KIND_FIXED64 = 3'd1;
  localparam logic [2:0] KIND_LENGTH  = 3'd2;
  localparam logic [2:0] KIND_FIXED32 = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;
  localparam logic [2:0] KIND_MSG_END = 3'd6;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_WIRE_TYPE = 2'd3;

  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN     = 3'd2;
  localparam logic [2:0] WIRE_SGROUP  = 3'd3;
  localparam logic [2:0] WIRE_EGROUP  = 3'd4;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;
  localparam logic [2:0] WIRE_RSVD6   = 3'd6;
  localparam logic [2:0] WIRE_RSVD7   = 3'd7;

  // register index (paddr[2])
  localparam logic       REG_PASS_PAYLOAD = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] token_value;
    logic [1:0]  error_code;
    logic        last_result;
  } result_t;

  // results caused by one input byte
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } rec_t;

  typedef struct packed {
    logic drop;
    logic tag_idle;
  } status_t;

endpackage

// ----- hw/rtl/pwt_parser.sv -----
// ----------------------------------------------------------------------------
// pwt_parser
// Parse state and the per-byte step: tag, varint, fixed and payload handling,
// error and message-end closing. Produces up to two results per byte.
// ----------------------------------------------------------------------------
module pwt_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  pwt_pkg::in_item_t din,
  input  logic              pass_payload,
  output logic              push,
  output pwt_pkg::rec_t     rec,
  output pwt_pkg::status_t  status
);

  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_VARINT  = 3'd1;
  localparam logic [2:0] PH_FIX64   = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_FIX32   = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  logic [2:0]  phase_r,  phase_nxt;
  logic [63:0] acc_r,    acc_nxt;
  logic [6:0]  shift_r,  shift_nxt;
  logic [31:0] field_r,  field_nxt;
  logic [2:0]  wire_r,   wire_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic        drop_r,   drop_nxt;

  logic [63:0] acc_v, acc_f, rem_dec;
  logic [6:0]  shift_p7, shift_p8;
  logic        go_tag, err, tok_v, trunc;
  logic [1:0]  ecode;
  logic [1:0]  cnt;
  pwt_pkg::result_t tok, close_res;

  assign acc_v    = acc_r | ({57'd0, din.data_byte[6:0]} << shift_r[5:0]);
  assign acc_f    = acc_r | ({56'd0, din.data_byte} << shift_r[5:0]);
  assign shift_p7 = shift_r + 7'd7;
  assign shift_p8 = shift_r + 7'd8;
  assign rem_dec  = (remain_r != 64'd0) ? remain_r - 64'd1 : remain_r;

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    shift_nxt  = shift_r;
    field_nxt  = field_r;
    wire_nxt   = wire_r;
    remain_nxt = remain_r;
    drop_nxt   = drop_r;
    go_tag     = 1'b0;
    err        = 1'b0;
    ecode      = pwt_pkg::ERR_NONE;
    tok_v      = 1'b0;
    tok        = '0;
    tok.field_number = field_r;
    tok.wire_type    = wire_r;
    tok.error_code   = pwt_pkg::ERR_NONE;

    unique case (phase_r)
      PH_TAG, PH_VARINT, PH_LENGTH: begin
        acc_nxt = acc_v;
        if (!din.data_byte[7]) begin
          acc_nxt   = '0;
          shift_nxt = '0;
          unique case (phase_r)
            PH_TAG: begin
              field_nxt = acc_v[34:3];
              wire_nxt  = acc_v[2:0];
              unique case (acc_v[2:0])
                pwt_pkg::WIRE_VARINT: phase_nxt = PH_VARINT;
                pwt_pkg::WIRE_FIXED64: begin
                  phase_nxt  = PH_FIX64;
                  remain_nxt = 64'd8;
                end
                pwt_pkg::WIRE_LEN: phase_nxt = PH_LENGTH;
                pwt_pkg::WIRE_FIXED32: begin
                  phase_nxt  = PH_FIX32;
                  remain_nxt = 64'd4;
                end
                default: begin
                  err   = 1'b1;
                  ecode = pwt_pkg::ERR_WIRE_TYPE;
                end
              endcase
            end
            PH_VARINT: begin
              tok_v           = 1'b1;
              tok.token_kind  = pwt_pkg::KIND_VARINT;
              tok.token_value = acc_v;
              go_tag          = 1'b1;
            end
            default: begin
              tok_v           = 1'b1;
              tok.token_kind  = pwt_pkg::KIND_LENGTH;
              tok.token_value = acc_v;
              if (acc_v == 64'd0) begin
                go_tag = 1'b1;
              end else begin
                phase_nxt  = PH_PAYLOAD;
                remain_nxt = acc_v;
              end
            end
          endcase
        end else begin
          shift_nxt = shift_p7;
          if (shift_p7 >= 7'd64) begin
            err   = 1'b1;
            ecode = pwt_pkg::ERR_MALFORMED;
          end
        end
      end
      PH_FIX64, PH_FIX32: begin
        acc_nxt    = acc_f;
        shift_nxt  = shift_p8;
        remain_nxt = rem_dec;
        if (rem_dec == 64'd0) begin
          tok_v           = 1'b1;
          tok.token_kind  = (phase_r == PH_FIX64) ? pwt_pkg::KIND_FIXED64
                                                  : pwt_pkg::KIND_FIXED32;
          tok.token_value = acc_f;
          go_tag          = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        tok_v           = pass_payload;
        tok.token_kind  = pwt_pkg::KIND_PAYLOAD;
        tok.token_value = {56'd0, din.data_byte};
        remain_nxt      = rem_dec;
        if (rem_dec == 64'd0) begin
          go_tag = 1'b1;
        end
      end
      default: begin
        go_tag = 1'b1;
      end
    endcase

    if (go_tag) begin
      phase_nxt  = PH_TAG;
      acc_nxt    = '0;
      shift_nxt  = '0;
      field_nxt  = '0;
      wire_nxt   = '0;
      remain_nxt = '0;
    end
  end

  assign trunc = (phase_nxt != PH_TAG) || (shift_nxt != 7'd0);

  always_comb begin
    close_res            = '0;
    close_res.token_kind = pwt_pkg::KIND_MSG_END;
    close_res.error_code = pwt_pkg::ERR_NONE;
    if (err || trunc) begin
      close_res.token_kind   = pwt_pkg::KIND_ERROR;
      close_res.field_number = field_nxt;
      close_res.wire_type    = wire_nxt;
      close_res.error_code   = err ? ecode : pwt_pkg::ERR_TRUNCATED;
    end
  end

  logic        clear;
  logic [2:0]  phase_f;
  logic [63:0] acc_fin, remain_fin;
  logic [6:0]  shift_fin;
  logic [31:0] field_fin;
  logic [2:0]  wire_fin;
  logic        drop_fin;

  always_comb begin
    cnt    = 2'd0;
    rec    = '0;
    clear  = 1'b0;
    drop_fin = drop_nxt;
    if (drop_r) begin
      if (din.end_of_message) begin
        cnt                 = 2'd1;
        rec.r0.token_kind   = pwt_pkg::KIND_MSG_END;
        rec.r0.error_code   = pwt_pkg::ERR_NONE;
        clear               = 1'b1;
        drop_fin            = 1'b0;
      end
    end else if (err) begin
      cnt      = 2'd1;
      rec.r0   = close_res;
      clear    = 1'b1;
      drop_fin = !din.end_of_message;
    end else if (din.end_of_message) begin
      clear    = 1'b1;
      drop_fin = 1'b0;
      if (tok_v) begin
        cnt    = 2'd2;
        rec.r0 = tok;
        rec.r1 = close_res;
      end else begin
        cnt    = 2'd1;
        rec.r0 = close_res;
      end
    end else if (tok_v) begin
      cnt    = 2'd1;
      rec.r0 = tok;
    end
    rec.two            = (cnt == 2'd2);
    rec.r0.last_result = (cnt != 2'd2);
    rec.r1.last_result = 1'b1;
  end

  assign phase_f    = clear ? PH_TAG : (drop_r ? phase_r  : phase_nxt);
  assign acc_fin    = clear ? '0     : (drop_r ? acc_r    : acc_nxt);
  assign shift_fin  = clear ? '0     : (drop_r ? shift_r  : shift_nxt);
  assign field_fin  = clear ? '0     : (drop_r ? field_r  : field_nxt);
  assign wire_fin   = clear ? '0     : (drop_r ? wire_r   : wire_nxt);
  assign remain_fin = clear ? '0     : (drop_r ? remain_r : remain_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG;
      acc_r    <= '0;
      shift_r  <= '0;
      field_r  <= '0;
      wire_r   <= '0;
      remain_r <= '0;
      drop_r   <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_f;
      acc_r    <= acc_fin;
      shift_r  <= shift_fin;
      field_r  <= field_fin;
      wire_r   <= wire_fin;
      remain_r <= remain_fin;
      drop_r   <= drop_fin;
    end
  end

  assign push            = step_en && (cnt != 2'd0);
  assign status.drop     = drop_r;
  assign status.tag_idle = (phase_r == PH_TAG) && (shift_r == 7'd0);

endmodule

// ----- hw/rtl/pwt_outq.sv -----
// ----------------------------------------------------------------------------
// pwt_outq
// Two-entry result queue. Each entry holds the one or two results of a byte;
// they leave one transfer at a time.
// ----------------------------------------------------------------------------
module pwt_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pwt_pkg::rec_t    rec,
  output logic             has_room,
  output logic             out_valid,
  input  logic             out_ready,
  output pwt_pkg::result_t out_data
);

  pwt_pkg::rec_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r, sub_r;
  logic [1:0] count_r;
  logic       xfer, pop;
  pwt_pkg::rec_t head;

  assign head      = mem_r[rd_ptr_r];
  assign out_valid = (count_r != 2'd0);
  assign out_data  = sub_r ? head.r1 : head.r0;
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && (sub_r || !head.two);
  assign has_room  = (count_r != 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      sub_r    <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (xfer) begin
        sub_r <= !pop;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/protobuf_wire_tokenizer.sv -----
// A byte's results are registered in a two-entry result queue when accepted.
// Throughput: one byte per cycle while the queue has room; a byte giving
// two results holds the output for two transfers, buffered in that queue.
// Reset: synchronous, active low; parse state clears to awaiting a tag and
// pass_payload returns to 1.
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer
// Protobuf wire-format tokenizer: one message byte in, up to two tokens out,
// with an APB-style register for payload pass-through.
// ----------------------------------------------------------------------------
module protobuf_wire_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pwt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pwt_pkg::result_t  out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic             pass_r;
  logic             step_en, push, has_room;
  pwt_pkg::rec_t    rec;
  pwt_pkg::status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pwt_pkg::REG_PASS_PAYLOAD) ? {31'd0, pass_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == pwt_pkg::REG_PASS_PAYLOAD)) begin
      pass_r <= pwdata[0];
    end
  end

  assign in_ready = has_room;
  assign step_en  = in_valid && in_ready;

  pwt_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .din          (in_data),
    .pass_payload (pass_r),
    .push         (push),
    .rec          (rec),
    .status       (status)
  );

  pwt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .rec       (rec),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    status.drop |-> status.tag_idle)
    else $error("drop mode with parse state not cleared");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.token_kind == pwt_pkg::KIND_MSG_END)
      |-> out_data.last_result)
    else $error("message end not the final result of its byte");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.token_kind == pwt_pkg::KIND_ERROR)
                   == (out_data.error_code != pwt_pkg::ERR_NONE)))
    else $error("error code inconsistent with token kind");

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (status.drop && step_en && !in_data.end_of_message) |-> !push)
    else $error("result produced while dropping");
`endif

endmodule
